// File: hdl/tli_pkg.sv
package tli_pkg;

	localparam int TABLE_ROWS    = 64;
	localparam int VALUE_COLUMNS = 5;

	localparam int ROW_W    = $clog2(TABLE_ROWS);
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int COL_W    = 3;
	localparam int CFG_W    = 7;
	localparam int ROWV_W   = VALUE_COLUMNS * VAL_W;
	localparam int PROD_W   = 2 * KEY_W;
	localparam int STEP_W   = $clog2(PROD_W);
	localparam int S_DATA_W = 240;
	localparam int M_DATA_W = 32;

	// s_tdata field offsets
	localparam int OFS_ROW_INDEX = 0;
	localparam int OFS_ROW_KEY   = OFS_ROW_INDEX + ROW_W;
	localparam int OFS_VALUES    = OFS_ROW_KEY + KEY_W;
	localparam int OFS_QUERY_KEY = OFS_VALUES + 5 * VAL_W;
	localparam int OFS_COLUMN    = OFS_QUERY_KEY + KEY_W;

	localparam logic ACTION_LOAD  = 1'b0;
	localparam logic ACTION_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK_LO,
		ST_CHK_HI,
		ST_SCAN,
		ST_DIRECT,
		ST_Y0,
		ST_Y1,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV,
		ST_DONE
	} state_t;

	function automatic logic [VAL_W-1:0] col_pick(logic [ROWV_W-1:0] row, logic [COL_W-1:0] col);
		logic [VAL_W-1:0] v;
		v = row[col*VAL_W +: VAL_W];
		return v;
	endfunction

endpackage

// File: hdl/tli_div.sv
module tli_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tli_pkg::PROD_W-1:0] dividend,
	input  logic [tli_pkg::KEY_W-1:0]  divisor,
	output logic                       done,
	output logic [tli_pkg::PROD_W-1:0] quotient
);
	import tli_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [KEY_W-1:0]    rem_q;
	logic [KEY_W-1:0]    d_q;
	logic [PROD_W-1:0]   quo_q;
	logic [KEY_W:0]      sh;
	logic                fits;

	// one restoring step per cycle
	assign sh   = {rem_q, quo_q[PROD_W-1]};
	assign fits = sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(PROD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			d_q   <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? KEY_W'(sh - {1'b0, d_q}) : sh[KEY_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: hdl/table_linear_interpolation_core.sv
// Piecewise linear table interpolation.
// s_* channel: one transfer is either a row load (s_tuser = 0), which writes a key and
// five value columns into the row given by row_index, or a query (s_tuser = 1), which
// interpolates the selected column at query_key. Loads return nothing; each query
// returns one transfer on m_*: the value in m_tdata and the clamped flag in m_tuser.
// cfg_* channel: rows_in_use, always ready; write it only while the block is idle.
// A load leaves the block in its idle state, so it is ready again at once.
// A query checks both table ends, walks the key memory one row per cycle,
// reads two value rows, multiplies once and runs a 64-step restoring divider.
// When the two neighbouring keys are not increasing, the lower row's value is returned
// without the multiply and divide; a key below row 0, above the last row in use or on
// the first key takes the value of that end row directly.
// s_tready stays low from the query transfer until m_tvalid rises and is high again in
// that same cycle.
// The result sits in an output register; a stalled receiver holds the finished
// query in that register and only the next query waits behind it.
// Reset clears the control state and sets rows_in_use to 2; the table memories are
// not cleared and must be loaded before they are queried.
module table_linear_interpolation_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// row_index, row_key, value_j0, value_j1, value_tau1, value_j2, value_tau2,
	// query_key, column_select, zero fill
	input  logic [tli_pkg::S_DATA_W-1:0] s_tdata,
	// action
	input  logic [0:0]                   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// interpolated_value
	output logic [tli_pkg::M_DATA_W-1:0] m_tdata,
	// clamped
	output logic [0:0]                   m_tuser,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tli_pkg::CFG_W-1:0]    cfg_data
);
	import tli_pkg::*;

	state_t state_q, state_d;

	logic [KEY_W-1:0]  key_mem [TABLE_ROWS];
	logic [ROWV_W-1:0] val_mem [TABLE_ROWS];
	logic [KEY_W-1:0]  key_rd_q;
	logic [ROWV_W-1:0] val_rd_q;

	logic [CFG_W-1:0]        rows_q;
	logic signed [KEY_W-1:0] k_q;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        last_q;
	logic [ROW_W-1:0]        scan_q;
	logic signed [KEY_W-1:0] prev_key_q;
	logic                    clamp_q;
	logic                    degen_q;
	logic [VAL_W-1:0]        y0_q;
	logic [VAL_W:0]          ady_q;
	logic                    neg_q;
	logic [KEY_W-1:0]        dk_q;
	logic [KEY_W-1:0]        dkk_q;
	logic [PROD_W-1:0]       prod_q;
	logic [VAL_W-1:0]        res_q;
	logic                    m_tvalid_q;
	logic [M_DATA_W-1:0]     m_tdata_q;
	logic                    m_tuser_q;

	logic                    s_xfer;
	logic                    load_xfer;
	logic                    query_xfer;
	logic                    out_free;
	logic signed [KEY_W-1:0] key_rd_s;
	logic                    key_lt;
	logic                    key_gt;
	logic                    scan_more;
	logic [ROW_W-1:0]        key_addr;
	logic [ROW_W-1:0]        val_addr;
	logic                    div_start;
	logic                    div_done;
	logic [PROD_W-1:0]       div_q;
	logic [VAL_W-1:0]        pick;
	logic signed [VAL_W:0]   dy;
	logic [PROD_W:0]         prod_full;
	logic [CFG_W-1:0]        n_rows;
	logic [COL_W-1:0]        col_in;

	assign s_xfer     = s_tvalid && s_tready;
	assign load_xfer  = s_xfer && (s_tuser[0] == ACTION_LOAD);
	assign query_xfer = s_xfer && (s_tuser[0] == ACTION_QUERY);
	assign out_free   = !m_tvalid_q || m_tready;

	assign key_rd_s  = key_rd_q;
	assign key_lt    = key_rd_s < k_q;
	assign key_gt    = key_rd_s > k_q;
	assign scan_more = (scan_q != last_q) && key_lt;
	assign pick      = col_pick(val_rd_q, col_q);
	assign dy        = $signed({pick[VAL_W-1], pick}) - $signed({y0_q[VAL_W-1], y0_q});
	assign prod_full = ady_q * dk_q;

	assign n_rows = (rows_q < CFG_W'(2)) ? CFG_W'(2) :
		(rows_q > CFG_W'(TABLE_ROWS)) ? CFG_W'(TABLE_ROWS) : rows_q;
	assign col_in = (s_tdata[OFS_COLUMN +: COL_W] >= COL_W'(VALUE_COLUMNS)) ?
		COL_W'(VALUE_COLUMNS - 1) : s_tdata[OFS_COLUMN +: COL_W];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (query_xfer) state_d = ST_CHK_LO;
			end
			ST_CHK_LO: begin
				state_d = key_gt ? ST_DIRECT : ST_CHK_HI;
			end
			ST_CHK_HI: begin
				if (key_lt || prev_key_q == k_q) state_d = ST_DIRECT;
				else state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (!scan_more) state_d = ST_Y0;
			end
			ST_DIRECT: state_d = ST_DONE;
			ST_Y0:     state_d = ST_Y1;
			ST_Y1: begin
				state_d = degen_q ? ST_DONE : ST_MUL;
			end
			ST_MUL:    state_d = ST_DIV_GO;
			ST_DIV_GO: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs and memory addresses
	always_comb begin
		s_tready  = 1'b0;
		key_addr  = '0;
		val_addr  = scan_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_CHK_LO: begin
				key_addr = last_q;
				val_addr = '0;
			end
			ST_CHK_HI: begin
				key_addr = ROW_W'(1);
				val_addr = key_lt ? last_q : '0;
			end
			ST_SCAN: begin
				key_addr = scan_q + 1'b1;
				val_addr = scan_q - 1'b1;
			end
			ST_Y0:     val_addr = scan_q;
			ST_DIV_GO: div_start = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_xfer) begin
			key_mem[s_tdata[OFS_ROW_INDEX +: ROW_W]] <= s_tdata[OFS_ROW_KEY +: KEY_W];
			val_mem[s_tdata[OFS_ROW_INDEX +: ROW_W]] <= s_tdata[OFS_VALUES +: ROWV_W];
		end
		key_rd_q <= key_mem[key_addr];
		val_rd_q <= val_mem[val_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rows_q     <= CFG_W'(2);
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) rows_q <= cfg_data;
			if (state_q == ST_DONE && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (query_xfer) begin
					k_q     <= s_tdata[OFS_QUERY_KEY +: KEY_W];
					col_q   <= col_in;
					last_q  <= ROW_W'(n_rows - 1'b1);
					clamp_q <= 1'b0;
				end
			end
			ST_CHK_LO: begin
				prev_key_q <= key_rd_s;
				clamp_q    <= key_gt;
			end
			ST_CHK_HI: begin
				scan_q  <= ROW_W'(1);
				clamp_q <= key_lt;
			end
			ST_SCAN: begin
				if (scan_more) begin
					prev_key_q <= key_rd_s;
					scan_q     <= scan_q + 1'b1;
				end else begin
					dk_q    <= KEY_W'(k_q - prev_key_q);
					dkk_q   <= KEY_W'(key_rd_s - prev_key_q);
					degen_q <= key_rd_s <= prev_key_q;
				end
			end
			ST_DIRECT: res_q <= pick;
			ST_Y0:     y0_q  <= pick;
			ST_Y1: begin
				res_q <= y0_q;
				neg_q <= dy[VAL_W];
				ady_q <= dy[VAL_W] ? (VAL_W+1)'(-dy) : dy;
			end
			ST_MUL: prod_q <= prod_full[PROD_W-1:0];
			ST_DIV: begin
				if (div_done) res_q <= neg_q ? y0_q - div_q[VAL_W-1:0] : y0_q + div_q[VAL_W-1:0];
			end
			ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= res_q;
					m_tuser_q <= clamp_q;
				end
			end
			default: begin
			end
		endcase
	end

	tli_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (dkk_q),
		.done     (div_done),
		.quotient (div_q)
	);

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;
	assign cfg_ready  = 1'b1;

	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> scan_q != '0 && scan_q <= last_q)
		else $error("scan index left the rows in use");

	assert property (@(posedge clk) disable iff (!arst_n)
		query_xfer |=> !s_tready)
		else $error("input ready while a query is in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_free |=> m_tvalid && state_q == ST_IDLE)
		else $error("finished query not moved to the output register");

endmodule
